[sv/go_to_point_pd_controller_core_defines.svh]
// assertion macros for the go-to-point pd controller
`ifndef GO_TO_POINT_PD_CONTROLLER_CORE_DEFINES_SVH
`define GO_TO_POINT_PD_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define GTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/gtp_pkg.sv]
// types, constants and the arctangent table of the go-to-point pd controller
package gtp_pkg;

    typedef struct packed {
        logic               begin_req;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [15:0]        heading;
        logic [31:0]        now_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] left_drive;
        logic signed [7:0] right_drive;
        logic [1:0]        status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ITER,
        ST_LIN_P,
        ST_LIN_D,
        ST_ANG_P,
        ST_ANG_D,
        ST_ACC,
        ST_MUL,
        ST_MIX
    } state_t;

    // register indexes
    localparam logic [2:0] REG_TARGET_X   = 3'd0;
    localparam logic [2:0] REG_TARGET_Y   = 3'd1;
    localparam logic [2:0] REG_KP_LIN     = 3'd2;
    localparam logic [2:0] REG_KD_LIN     = 3'd3;
    localparam logic [2:0] REG_KP_ANG     = 3'd4;
    localparam logic [2:0] REG_KD_ANG     = 3'd5;
    localparam logic [2:0] REG_TOLERANCE  = 3'd6;
    localparam logic [2:0] REG_TIMEOUT    = 3'd7;

    // register reset values
    localparam logic [15:0] KP_LIN_RST    = 16'd819;
    localparam logic [15:0] KD_LIN_RST    = 16'd205;
    localparam logic [15:0] KP_ANG_RST    = 16'd1536;
    localparam logic [15:0] KD_ANG_RST    = 16'd307;
    localparam logic [15:0] TOLERANCE_RST = 16'd16;
    localparam logic [19:0] TIMEOUT_RST   = 20'd10000;

    // status codes
    localparam logic [1:0] STATUS_RUN     = 2'd0;
    localparam logic [1:0] STATUS_REACHED = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    // iteration counts and limits
    localparam logic [4:0] SQRT_LAST     = 5'd24;
    localparam logic [4:0] CORDIC_STEPS  = 5'd20;
    localparam logic [30:0] PI29         = 31'd1686629713;
    localparam logic signed [49:0] LIN_LIM = 50'sd491520;
    localparam logic signed [40:0] ACC_LIM = 41'sd16777216;
    localparam logic [19:0] W_LIM        = 20'd131072;
    localparam logic signed [26:0] MIX_LIM = 27'sd8323072;

    // arctangent of 2^-i in 2^32 turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0:    t = 32'd536870912;
            5'd1:    t = 32'd316933406;
            5'd2:    t = 32'd167458907;
            5'd3:    t = 32'd85004756;
            5'd4:    t = 32'd42667331;
            5'd5:    t = 32'd21354465;
            5'd6:    t = 32'd10679838;
            5'd7:    t = 32'd5340245;
            5'd8:    t = 32'd2670163;
            5'd9:    t = 32'd1335087;
            5'd10:   t = 32'd667544;
            5'd11:   t = 32'd333772;
            5'd12:   t = 32'd166886;
            5'd13:   t = 32'd83443;
            5'd14:   t = 32'd41722;
            5'd15:   t = 32'd20861;
            5'd16:   t = 32'd10430;
            5'd17:   t = 32'd5215;
            5'd18:   t = 32'd2608;
            5'd19:   t = 32'd1304;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

[sv/go_to_point_pd_controller_core.sv]
// Go-to-point pd controller: one tick in, one drive command out. An accepted tick passes
// through the shared 25-step loop that runs the two-bit-per-cycle square root and the
// 20-step cordic bearing side by side; the next tick is taken once the block is back in
// idle, so a new tick is not taken before the last one is through. The result register
// holds a finished command while the downstream side stalls.
`include "go_to_point_pd_controller_core_defines.svh"

module go_to_point_pd_controller_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  gtp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output gtp_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    // control and configuration
    gtp_pkg::state_t    state_reg, state_next;
    logic [4:0]         cnt_reg;
    logic               out_valid_reg;
    logic signed [23:0] tx_reg, ty_reg;
    logic [15:0]        kp_lin_reg, kd_lin_reg, kp_ang_reg, kd_ang_reg, tol_reg;
    logic [19:0]        timeout_reg;
    logic [31:0]        start_reg;
    logic [24:0]        prev_dist_reg;
    logic signed [15:0] prev_e_reg;

    // datapath registers
    logic signed [24:0] dx_reg, dy_reg;
    logic [15:0]        head_reg;
    logic [31:0]        now_reg;
    logic [48:0]        sqx_reg;
    logic [49:0]        v_reg;
    logic [26:0]        rem_reg;
    logic [24:0]        root_reg;
    logic signed [43:0] x_reg, y_reg;
    logic [31:0]        ang_reg;
    logic               zero_reg;
    logic signed [15:0] e_reg;
    logic [40:0]        pkp_reg;
    logic signed [48:0] pkd_reg;
    logic signed [19:0] lin_reg;
    logic signed [32:0] a1_reg;
    logic signed [39:0] a2_reg;
    logic [24:0]        mag_reg;
    logic               neg_reg;
    logic [55:0]        prod_reg;
    gtp_pkg::out_item_t out_reg;

    logic accept, out_free, iter_last;

    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign iter_last = (cnt_reg == gtp_pkg::SQRT_LAST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gtp_pkg::ST_IDLE:  if (in_valid) state_next = gtp_pkg::ST_SQX;
            gtp_pkg::ST_SQX:   state_next = gtp_pkg::ST_SQY;
            gtp_pkg::ST_SQY:   state_next = gtp_pkg::ST_ITER;
            gtp_pkg::ST_ITER:  if (iter_last) state_next = gtp_pkg::ST_LIN_P;
            gtp_pkg::ST_LIN_P: state_next = gtp_pkg::ST_LIN_D;
            gtp_pkg::ST_LIN_D: state_next = gtp_pkg::ST_ANG_P;
            gtp_pkg::ST_ANG_P: state_next = gtp_pkg::ST_ANG_D;
            gtp_pkg::ST_ANG_D: state_next = gtp_pkg::ST_ACC;
            gtp_pkg::ST_ACC:   state_next = gtp_pkg::ST_MUL;
            gtp_pkg::ST_MUL:   state_next = gtp_pkg::ST_MIX;
            gtp_pkg::ST_MIX:   if (out_free) state_next = gtp_pkg::ST_IDLE;
            default:           state_next = gtp_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall  = (state_reg != gtp_pkg::ST_IDLE);
        out_valid = out_valid_reg;
        out_data  = out_reg;
    end

    // differences to target
    logic signed [24:0] dx_in, dy_in;
    assign dx_in = {tx_reg[23], tx_reg} - {in_data.pos_x[23], in_data.pos_x};
    assign dy_in = {ty_reg[23], ty_reg} - {in_data.pos_y[23], in_data.pos_y};

    // squares
    logic signed [49:0] sq_x, sq_y;
    assign sq_x = dx_reg * dx_reg;
    assign sq_y = dy_reg * dy_reg;

    // square root step, two bits of the radicand per cycle
    logic [26:0] rem_sh, trial;
    logic        take;
    assign rem_sh = {rem_reg[24:0], v_reg[49:48]};
    assign trial  = {root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    // cordic step
    logic signed [43:0] xs, ys;
    logic               y_pos;
    logic [31:0]        turn;
    assign xs    = x_reg >>> cnt_reg;
    assign ys    = y_reg >>> cnt_reg;
    assign y_pos = !y_reg[43] && (y_reg != '0);
    assign turn  = gtp_pkg::atan_turn(cnt_reg);

    // bearing rounded to 16 bits and heading error
    logic [31:0]        ang_rnd;
    logic [15:0]        bearing;
    logic signed [15:0] e_now;
    assign ang_rnd = ang_reg + 32'h0000_8000;
    assign bearing = zero_reg ? 16'd0 : ang_rnd[31:16];
    assign e_now   = $signed(bearing - head_reg);

    // gain products
    logic [21:0]        kd50_lin, kd50_ang;
    logic signed [25:0] dd;
    logic signed [16:0] de;
    logic signed [49:0] lin_sum;
    logic signed [40:0] acc_sum;
    assign kd50_lin = {1'b0, kd_lin_reg, 5'b0} + {2'b0, kd_lin_reg, 4'b0}
                    + {5'b0, kd_lin_reg, 1'b0};
    assign kd50_ang = {1'b0, kd_ang_reg, 5'b0} + {2'b0, kd_ang_reg, 4'b0}
                    + {5'b0, kd_ang_reg, 1'b0};
    assign dd       = $signed({1'b0, root_reg}) - $signed({1'b0, prev_dist_reg});
    assign de       = {e_reg[15], e_reg} - {prev_e_reg[15], prev_e_reg};
    assign lin_sum  = $signed({9'b0, pkp_reg}) + {pkd_reg[48], pkd_reg};
    assign acc_sum  = {{8{a1_reg[32]}}, a1_reg} + {a2_reg[39], a2_reg};

    // angular rate, mixing and stop decision
    logic [19:0]        w_raw;
    logic [17:0]        w_mag;
    logic signed [18:0] w_val;
    logic signed [25:0] w55;
    logic signed [26:0] l16, left_sum, right_sum;
    logic [31:0]        elapsed;
    logic [1:0]         status;
    assign w_raw     = prod_reg[55:36];
    assign w_mag     = (w_raw > gtp_pkg::W_LIM) ? gtp_pkg::W_LIM[17:0] : w_raw[17:0];
    assign w_val     = neg_reg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    assign w55       = ({{7{w_val[18]}}, w_val} <<< 6) - ({{7{w_val[18]}}, w_val} <<< 3)
                     - {{7{w_val[18]}}, w_val};
    assign l16       = {{3{lin_reg[19]}}, lin_reg, 4'b0};
    assign left_sum  = l16 - {w55[25], w55};
    assign right_sum = l16 + {w55[25], w55};
    assign elapsed   = now_reg - start_reg;

    always_comb
    begin
        if (root_reg < {9'b0, tol_reg})
            status = gtp_pkg::STATUS_REACHED;
        else if (elapsed > {12'b0, timeout_reg})
            status = gtp_pkg::STATUS_TIMEOUT;
        else
            status = gtp_pkg::STATUS_RUN;
    end

    // clamp to full scale and truncate toward zero
    function automatic logic signed [7:0] drive_of(input logic signed [26:0] v);
        logic signed [26:0] c;
        logic [26:0]        m;
        logic [7:0]         q;
        c = (v > gtp_pkg::MIX_LIM) ? gtp_pkg::MIX_LIM :
            ((v < -gtp_pkg::MIX_LIM) ? -gtp_pkg::MIX_LIM : v);
        m = c[26] ? 27'(-c) : 27'(c);
        q = m[23:16];
        return c[26] ? $signed(-q) : $signed(q);
    endfunction

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gtp_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            prev_dist_reg <= '0;
            prev_e_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gtp_pkg::ST_SQY)
                cnt_reg <= '0;
            else if (state_reg == gtp_pkg::ST_ITER)
                cnt_reg <= cnt_reg + 5'd1;
            if (state_reg == gtp_pkg::ST_MIX && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (accept && in_data.begin_req)
            begin
                start_reg     <= in_data.now_ms;
                prev_dist_reg <= '0;
                prev_e_reg    <= '0;
            end
            if (state_reg == gtp_pkg::ST_MIX && out_free)
            begin
                prev_dist_reg <= root_reg;
                prev_e_reg    <= e_reg;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg      <= '0;
            ty_reg      <= '0;
            kp_lin_reg  <= gtp_pkg::KP_LIN_RST;
            kd_lin_reg  <= gtp_pkg::KD_LIN_RST;
            kp_ang_reg  <= gtp_pkg::KP_ANG_RST;
            kd_ang_reg  <= gtp_pkg::KD_ANG_RST;
            tol_reg     <= gtp_pkg::TOLERANCE_RST;
            timeout_reg <= gtp_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gtp_pkg::REG_TARGET_X:  tx_reg      <= $signed(cfg_data);
                gtp_pkg::REG_TARGET_Y:  ty_reg      <= $signed(cfg_data);
                gtp_pkg::REG_KP_LIN:    kp_lin_reg  <= cfg_data[15:0];
                gtp_pkg::REG_KD_LIN:    kd_lin_reg  <= cfg_data[15:0];
                gtp_pkg::REG_KP_ANG:    kp_ang_reg  <= cfg_data[15:0];
                gtp_pkg::REG_KD_ANG:    kd_ang_reg  <= cfg_data[15:0];
                gtp_pkg::REG_TOLERANCE: tol_reg     <= cfg_data[15:0];
                gtp_pkg::REG_TIMEOUT:   timeout_reg <= cfg_data[19:0];
                default:                tx_reg      <= tx_reg;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            gtp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    dx_reg   <= dx_in;
                    dy_reg   <= dy_in;
                    head_reg <= in_data.heading;
                    now_reg  <= in_data.now_ms;
                end
            end
            gtp_pkg::ST_SQX:
            begin
                sqx_reg  <= sq_x[48:0];
                zero_reg <= (dx_reg == '0) && (dy_reg == '0);
                // fold the left half plane by a half turn
                if (dx_reg[24])
                begin
                    x_reg   <= -{{3{dx_reg[24]}}, dx_reg, 16'b0};
                    y_reg   <= -{{3{dy_reg[24]}}, dy_reg, 16'b0};
                    ang_reg <= 32'h8000_0000;
                end
                else
                begin
                    x_reg   <= {{3{dx_reg[24]}}, dx_reg, 16'b0};
                    y_reg   <= {{3{dy_reg[24]}}, dy_reg, 16'b0};
                    ang_reg <= '0;
                end
            end
            gtp_pkg::ST_SQY:
            begin
                v_reg    <= {1'b0, sqx_reg} + {1'b0, sq_y[48:0]};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            gtp_pkg::ST_ITER:
            begin
                v_reg <= {v_reg[47:0], 2'b0};
                if (take)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[23:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[23:0], 1'b0};
                end
                if (cnt_reg < gtp_pkg::CORDIC_STEPS)
                begin
                    if (y_pos)
                    begin
                        x_reg   <= x_reg + ys;
                        y_reg   <= y_reg - xs;
                        ang_reg <= ang_reg + turn;
                    end
                    else
                    begin
                        x_reg   <= x_reg - ys;
                        y_reg   <= y_reg + xs;
                        ang_reg <= ang_reg - turn;
                    end
                end
            end
            gtp_pkg::ST_LIN_P:
            begin
                pkp_reg <= kp_lin_reg * root_reg;
                e_reg   <= e_now;
            end
            gtp_pkg::ST_LIN_D:
            begin
                pkd_reg <= $signed({1'b0, kd50_lin}) * dd;
            end
            gtp_pkg::ST_ANG_P:
            begin
                if (lin_sum > gtp_pkg::LIN_LIM)
                    lin_reg <= gtp_pkg::LIN_LIM[19:0];
                else if (lin_sum < -gtp_pkg::LIN_LIM)
                    lin_reg <= 20'(-gtp_pkg::LIN_LIM);
                else
                    lin_reg <= lin_sum[19:0];
                a1_reg <= $signed({1'b0, kp_ang_reg}) * e_reg;
            end
            gtp_pkg::ST_ANG_D:
            begin
                a2_reg <= $signed({1'b0, kd50_ang}) * de;
            end
            gtp_pkg::ST_ACC:
            begin
                neg_reg <= acc_sum[40];
                if (acc_sum > gtp_pkg::ACC_LIM || acc_sum < -gtp_pkg::ACC_LIM)
                    mag_reg <= 25'h100_0000;
                else if (acc_sum[40])
                    mag_reg <= 25'(-acc_sum);
                else
                    mag_reg <= acc_sum[24:0];
            end
            gtp_pkg::ST_MUL:
            begin
                prod_reg <= mag_reg * gtp_pkg::PI29;
            end
            gtp_pkg::ST_MIX:
            begin
                if (out_free)
                begin
                    out_reg.status <= status;
                    if (status != gtp_pkg::STATUS_RUN)
                    begin
                        out_reg.left_drive  <= '0;
                        out_reg.right_drive <= '0;
                    end
                    else
                    begin
                        out_reg.left_drive  <= drive_of(left_sum);
                        out_reg.right_drive <= drive_of(right_sum);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // checks
    `GTP_ASSERT_NEXT(a_accept_starts, accept, state_reg == gtp_pkg::ST_SQX,
                     "accepted tick did not start the square stage")
    `GTP_ASSERT_NOW(a_iter_bound, state_reg == gtp_pkg::ST_ITER, cnt_reg <= gtp_pkg::SQRT_LAST,
                    "iteration counter ran past the last step")
    `GTP_ASSERT_NOW(a_stop_zero, out_valid_reg && out_reg.status != gtp_pkg::STATUS_RUN,
                    out_reg.left_drive == 8'sd0 && out_reg.right_drive == 8'sd0,
                    "stopped tick carries nonzero drive")

endmodule

[bench/testbench.sv]
// self-checking testbench for the go-to-point pd controller core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    gtp_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    gtp_pkg::out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = gtp_pkg::REG_TARGET_X;
    logic [23:0] cfg_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int cycles = 0;
    gtp_pkg::out_item_t drive_queue[$];

    // controller copy: registers and tick state
    longint tgt_x, tgt_y, kp_lin, kd_lin, kp_ang, kd_ang, tol, tmo;
    bit [31:0] move_start;
    longint last_dist, last_err;

    // cordic angles of 2^-i in 2^32 turn units
    localparam bit [31:0] ATAN_TURNS [20] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304
    };

    go_to_point_pd_controller_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic longint clip(longint v, longint lim);
        return v < -lim ? -lim : (v > lim ? lim : v);
    endfunction

    function automatic longint shift_toward_zero(longint v, int s);
        return v < 0 ? -((-v) >>> s) : (v >>> s);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // bearing as a 16-bit binary angle, folded into the right half plane
    function automatic bit [15:0] bearing_of(longint dx, longint dy);
        longint x, y, xs, ys;
        bit [31:0] ang;
        bit [31:0] rounded;
        x = dx * 65536;
        y = dy * 65536;
        ang = 0;
        if (dx == 0 && dy == 0)
            return 16'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < 20; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys; y = y - xs; ang = ang + ATAN_TURNS[i];
            end
            else
            begin
                x = x - ys; y = y + xs; ang = ang - ATAN_TURNS[i];
            end
        end
        rounded = ang + 32'h8000;
        return rounded[31:16];
    endfunction

    // drive command for one tick, advancing the tick state
    function automatic gtp_pkg::out_item_t predict_drive(gtp_pkg::in_item_t t);
        longint dx, dy, distance, e, lin, acc, w, left, right;
        bit [15:0] diff;
        bit [31:0] elapsed;
        gtp_pkg::out_item_t r;
        if (t.begin_req)
        begin
            move_start = t.now_ms;
            last_dist = 0;
            last_err = 0;
        end
        dx = tgt_x - longint'(t.pos_x);
        dy = tgt_y - longint'(t.pos_y);
        distance = int_sqrt(longint'(dx * dx + dy * dy));
        diff = bearing_of(dx, dy) - t.heading;
        e = longint'(signed'(diff));
        lin = clip(kp_lin * distance + 50 * kd_lin * (distance - last_dist), 120 * 4096);
        acc = clip(kp_ang * e + 50 * kd_ang * (e - last_err), 64'sd1 << 24);
        w = clip(shift_toward_zero(acc * 64'sd1686629713, 36), 2 * 65536);
        left = shift_toward_zero(clip(lin * 16 - 55 * w, 127 * 65536), 16);
        right = shift_toward_zero(clip(lin * 16 + 55 * w, 127 * 65536), 16);
        last_dist = distance & 64'h1FF_FFFF;
        last_err = e;
        elapsed = t.now_ms - move_start;
        if (distance < tol)
            r.status = gtp_pkg::STATUS_REACHED;
        else if (longint'(elapsed) > tmo)
            r.status = gtp_pkg::STATUS_TIMEOUT;
        else
            r.status = gtp_pkg::STATUS_RUN;
        if (r.status != gtp_pkg::STATUS_RUN)
        begin
            left = 0;
            right = 0;
        end
        r.left_drive = left[7:0];
        r.right_drive = right[7:0];
        return r;
    endfunction

    // receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // compare each result transfer with the oldest expected command
    always @(posedge clk)
    begin
        gtp_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_queue.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result %p", $time, out_data);
            end
            else
            begin
                want = drive_queue.pop_front();
                if (out_data.left_drive !== want.left_drive)
                begin
                    errors++;
                    $display("%0t left_drive expected %0d got %0d", $time,
                             want.left_drive, out_data.left_drive);
                end
                if (out_data.right_drive !== want.right_drive)
                begin
                    errors++;
                    $display("%0t right_drive expected %0d got %0d", $time,
                             want.right_drive, out_data.right_drive);
                end
                if (out_data.status !== want.status)
                begin
                    errors++;
                    $display("%0t status expected %0d got %0d", $time,
                             want.status, out_data.status);
                end
            end
        end
    end

    // one tick transfer, with random sender idling before it
    task automatic send_tick(gtp_pkg::in_item_t t);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        do
            @(posedge clk);
        while (in_stall);
        drive_queue.push_back(predict_drive(t));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (drive_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[23:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            gtp_pkg::REG_TARGET_X:  tgt_x = longint'(signed'(value[23:0]));
            gtp_pkg::REG_TARGET_Y:  tgt_y = longint'(signed'(value[23:0]));
            gtp_pkg::REG_KP_LIN:    kp_lin = value & 16'hFFFF;
            gtp_pkg::REG_KD_LIN:    kd_lin = value & 16'hFFFF;
            gtp_pkg::REG_KP_ANG:    kp_ang = value & 16'hFFFF;
            gtp_pkg::REG_KD_ANG:    kd_ang = value & 16'hFFFF;
            gtp_pkg::REG_TOLERANCE: tol = value & 16'hFFFF;
            default:                tmo = value & 20'hFFFFF;
        endcase
    endtask

    function automatic gtp_pkg::in_item_t make_tick(bit b, longint px, longint py,
                                                    bit [15:0] h, bit [31:0] now);
        gtp_pkg::in_item_t t;
        t.begin_req = b;
        t.pos_x = px[23:0];
        t.pos_y = py[23:0];
        t.heading = h;
        t.now_ms = now;
        return t;
    endfunction

    function automatic gtp_pkg::in_item_t noise_tick();
        return make_tick(1'($urandom_range(1)), $urandom, $urandom, 16'($urandom), $urandom);
    endfunction

    // field extremes, zero offset, begin, reached, timeout and wrapping time
    task automatic test_directed();
        send_tick(make_tick(0, 0, 0, 0, 0));
        send_tick(make_tick(0, 100, -50, 16'h4000, 5));
        send_tick(make_tick(0, 1000, 0, 16'hFFFF, 10001));
        send_tick(make_tick(1, 1000, 0, 16'h8000, 32'hFFFF_FFF0));
        send_tick(make_tick(0, 900, 20, 16'h7FFF, 32'd9000));
        send_tick(make_tick(0, 800, 40, 16'h0000, 32'd10000));
        send_tick(make_tick(0, 8, 3, 16'h1234, 32'd10010));
        send_tick(make_tick(0, -8388608, -8388608, 16'hFFFF, 32'hFFFF_FFFF));
        send_tick(make_tick(1, 8388607, 8388607, 16'h0001, 32'h8000_0000));
        send_tick(make_tick(0, 8388607, -8388608, 16'hC000, 32'h8000_0014));
        send_tick(make_tick(0, -200, 0, 16'h8000, 32'h8000_0028));
        send_tick(make_tick(0, 0, -300, 16'hC000, 32'h8000_003C));
        send_tick(make_tick(0, 0, 300, 16'h4000, 32'h8000_0050));
        wait_idle();
        write_reg(gtp_pkg::REG_TARGET_X, -8388608);
        write_reg(gtp_pkg::REG_TARGET_Y, 8388607);
        write_reg(gtp_pkg::REG_KP_LIN, 65535);
        write_reg(gtp_pkg::REG_KD_LIN, 65535);
        write_reg(gtp_pkg::REG_KP_ANG, 65535);
        write_reg(gtp_pkg::REG_KD_ANG, 65535);
        write_reg(gtp_pkg::REG_TOLERANCE, 0);
        write_reg(gtp_pkg::REG_TIMEOUT, 1048575);
        send_tick(make_tick(1, 8388607, -8388608, 16'h0000, 0));
        send_tick(make_tick(0, -8388608, 8388607, 16'hFFFF, 20));
        send_tick(make_tick(0, -8388500, 8388000, 16'h8000, 32'd1048576));
        wait_idle();
        write_reg(gtp_pkg::REG_KP_LIN, 0);
        write_reg(gtp_pkg::REG_KD_LIN, 0);
        write_reg(gtp_pkg::REG_KP_ANG, 0);
        write_reg(gtp_pkg::REG_KD_ANG, 0);
        write_reg(gtp_pkg::REG_TOLERANCE, 65535);
        write_reg(gtp_pkg::REG_TIMEOUT, 0);
        send_tick(make_tick(1, 0, 0, 16'h1000, 100));
        send_tick(make_tick(0, -8388608, 0, 16'h1000, 101));
        send_tick(make_tick(0, 0, 0, 16'h1000, 100));
        wait_idle();
    endtask

    // moves toward a target with random content, mixed with noise ticks
    task automatic test_random(int ticks);
        int sent;
        int steps;
        longint scale, ox, oy;
        bit [31:0] now;
        bit [15:0] head;
        sent = 0;
        while (sent < ticks)
        begin
            if ($urandom_range(99) < 20)
            begin
                send_tick(noise_tick());
                sent++;
            end
            else
            begin
                steps = $urandom_range(3, 12);
                case ($urandom_range(2))
                    0: scale = 20000;
                    1: scale = 2000;
                    default: scale = 60;
                endcase
                now = $urandom;
                head = 16'($urandom);
                for (int k = 0; k < steps; k++)
                begin
                    ox = longint'($urandom_range(2 * scale)) - scale;
                    oy = longint'($urandom_range(2 * scale)) - scale;
                    head = head + 16'($urandom_range(2000)) - 16'd1000;
                    send_tick(make_tick(k == 0, tgt_x + ox, tgt_y + oy, head, now));
                    now = now + ($urandom_range(9) == 0 ? $urandom_range(5000) : 20);
                    scale = scale * 3 / 4 + 1;
                    sent++;
                end
            end
        end
        wait_idle();
    endtask

    // one register setting with targets kept away from the range edges
    task automatic random_settings();
        write_reg(gtp_pkg::REG_TARGET_X, longint'($urandom_range(8000000)) - 4000000);
        write_reg(gtp_pkg::REG_TARGET_Y, longint'($urandom_range(8000000)) - 4000000);
        write_reg(gtp_pkg::REG_KP_LIN, $urandom_range(65535));
        write_reg(gtp_pkg::REG_KD_LIN, $urandom_range(2) == 0 ? $urandom_range(65535)
                                                              : $urandom_range(600));
        write_reg(gtp_pkg::REG_KP_ANG, $urandom_range(4000));
        write_reg(gtp_pkg::REG_KD_ANG, $urandom_range(65535));
        write_reg(gtp_pkg::REG_TOLERANCE, $urandom_range(200));
        write_reg(gtp_pkg::REG_TIMEOUT, $urandom_range(2) == 0 ? $urandom_range(1048575)
                                                               : $urandom_range(400));
    endtask

    // idling phases: none, sender, receiver, both
    task automatic test_idling_phases();
        int idle_set[4] = '{0, 73, 0, 14};
        int stall_set[4] = '{0, 0, 73, 14};
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            for (int s = 0; s < 4; s++)
            begin
                random_settings();
                test_random(120);
            end
        end
    endtask

    initial
    begin
        tgt_x = 0; tgt_y = 0;
        kp_lin = gtp_pkg::KP_LIN_RST; kd_lin = gtp_pkg::KD_LIN_RST;
        kp_ang = gtp_pkg::KP_ANG_RST; kd_ang = gtp_pkg::KD_ANG_RST;
        tol = gtp_pkg::TOLERANCE_RST; tmo = gtp_pkg::TIMEOUT_RST;
        move_start = 0; last_dist = 0; last_err = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_idling_phases();
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/gtp_pkg.sv
sv/go_to_point_pd_controller_core.sv
bench/testbench.sv
